>>> rtl/mabt_pkg.sv
// Shared types and constants for the MAC address block table.
// Used by the table sequencer, the address store and the port checker.
`default_nettype none

package mabt_pkg;

    localparam int ENTRIES   = 32;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ADDR_W    = 64;
    localparam int CMD_W     = 3;
    localparam int SIDX_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 5;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 80;

    typedef enum logic [CMD_W-1:0] {
        CMD_FIND   = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [ADDR_W-1:0] wr_data;
    } store_req_t;

endpackage

`default_nettype wire

>>> rtl/mac_address_block_table.sv
// Top level of the MAC address block table: command sequencer, valid marks and
// the shared compare unit. Depends on mabt_pkg and mabt_store.
//
//   Channel | Direction | Ports                          | Contents
//   --------+-----------+--------------------------------+------------------------
//   command | in        | s_tvalid, s_tready, s_tdata    | command, address, index
//   result  | out       | m_tvalid, m_tready, m_tdata    | status, slot, entry
//
// Find, add and remove scan the store one entry per cycle through its single read
// port; ST_DRAIN follows the scan, then ST_APPLY and ST_DONE.
// Read entry passes through ST_READ before ST_APPLY; clear all or an unused code
// goes straight to ST_APPLY. The next command is taken in the cycle after the
// result is loaded.
// The block takes one command at a time; a result waiting on m_tready holds the next.
// Reset is synchronous and clears the valid marks and the store's written flags at
// once, so every entry reads as zero.
`default_nettype none

module mac_address_block_table (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // command [2:0], mac_address [66:3], slot_index [74:67], zero fill
    input  wire logic [mabt_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // status [1:0], slot [6:2], already_present [7], entry_address [71:8],
    // entry_valid [72], zero fill
    output logic [mabt_pkg::M_TDATA_W-1:0]     m_tdata
);
    import mabt_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_READ  = 6'b001000,
        ST_APPLY = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [SIDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]    hit_slot_reg, hit_slot_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_slot_reg, free_slot_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic                res_present_reg, res_present_next;
    logic [ADDR_W-1:0]   res_eaddr_reg, res_eaddr_next;
    logic                res_evalid_reg, res_evalid_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    store_req_t          req;
    logic [ADDR_W-1:0]   rd_data;
    logic                cmp_hit;
    logic                cmp_free;
    logic                idx_in_range;
    logic                s_xfer;

    mabt_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rd_data (rd_data)
    );

    assign s_tready     = (state_reg == ST_IDLE);
    assign s_xfer       = s_tvalid && s_tready;
    assign cmp_hit      = cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_data == addr_reg);
    assign cmp_free     = cmp_vld_reg && !valid_reg[cmp_idx_reg];
    assign idx_in_range = ({1'b0, idx_reg} < 9'(ENTRIES));

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        addr_next        = addr_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        cmp_vld_next     = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        hit_found_next   = hit_found_reg;
        hit_slot_next    = hit_slot_reg;
        free_found_next  = free_found_reg;
        free_slot_next   = free_slot_reg;
        valid_next       = valid_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        res_present_next = res_present_reg;
        res_eaddr_next   = res_eaddr_reg;
        res_evalid_next  = res_evalid_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        req.rd_addr      = cnt_reg;
        req.wr_en        = 1'b0;
        req.wr_addr      = '0;
        req.wr_data      = '0;

        if (cmp_hit && !hit_found_reg) begin
            hit_found_next = 1'b1;
            hit_slot_next  = cmp_idx_reg;
        end
        if (cmp_free && !free_found_reg) begin
            free_found_next = 1'b1;
            free_slot_next  = cmp_idx_reg;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    cmd_next        = cmd_t'(s_tdata[2:0]);
                    addr_next       = s_tdata[66:3];
                    idx_next        = s_tdata[74:67];
                    cnt_next        = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    case (cmd_t'(s_tdata[2:0]))
                        CMD_FIND, CMD_ADD, CMD_REMOVE: state_next = ST_SCAN;
                        CMD_READ:                      state_next = ST_READ;
                        default:                       state_next = ST_APPLY;
                    endcase
                end
            end
            ST_SCAN: begin
                cmp_vld_next = 1'b1;
                cmp_idx_next = cnt_reg;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(ENTRIES - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_APPLY;
            end
            ST_READ: begin
                req.rd_addr = idx_reg[IDX_W-1:0];
                state_next  = ST_APPLY;
            end
            ST_APPLY: begin
                res_status_next  = ST_OK;
                res_slot_next    = '0;
                res_present_next = 1'b0;
                res_eaddr_next   = '0;
                res_evalid_next  = 1'b0;
                case (cmd_reg)
                    CMD_FIND: begin
                        if (hit_found_reg) begin
                            res_slot_next = SLOT_W'(hit_slot_reg);
                        end else begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    CMD_ADD: begin
                        if (hit_found_reg) begin
                            res_slot_next    = SLOT_W'(hit_slot_reg);
                            res_present_next = 1'b1;
                        end else if (free_found_reg) begin
                            req.wr_en                 = 1'b1;
                            req.wr_addr               = free_slot_reg;
                            req.wr_data               = addr_reg;
                            valid_next[free_slot_reg] = 1'b1;
                            res_slot_next             = SLOT_W'(free_slot_reg);
                        end else begin
                            res_status_next = ST_FULL;
                        end
                    end
                    CMD_REMOVE: begin
                        if (hit_found_reg) begin
                            req.wr_en                = 1'b1;
                            req.wr_addr              = hit_slot_reg;
                            valid_next[hit_slot_reg] = 1'b0;
                            res_slot_next            = SLOT_W'(hit_slot_reg);
                        end else begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    CMD_CLEAR: begin
                        valid_next = '0;
                    end
                    CMD_READ: begin
                        if (idx_in_range) begin
                            res_slot_next   = SLOT_W'(idx_reg);
                            res_eaddr_next  = rd_data;
                            res_evalid_next = valid_reg[idx_reg[IDX_W-1:0]];
                        end else begin
                            res_status_next = ST_RANGE;
                        end
                    end
                    default: begin
                    end
                endcase
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, res_evalid_reg, res_eaddr_reg, res_present_reg,
                                     res_slot_reg, res_status_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cmp_vld_reg  <= 1'b0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cmp_vld_reg  <= cmp_vld_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg         <= cmd_next;
        addr_reg        <= addr_next;
        idx_reg         <= idx_next;
        cnt_reg         <= cnt_next;
        cmp_idx_reg     <= cmp_idx_next;
        hit_found_reg   <= hit_found_next;
        hit_slot_reg    <= hit_slot_next;
        free_found_reg  <= free_found_next;
        free_slot_reg   <= free_slot_next;
        res_status_reg  <= res_status_next;
        res_slot_reg    <= res_slot_next;
        res_present_reg <= res_present_next;
        res_eaddr_reg   <= res_eaddr_next;
        res_evalid_reg  <= res_evalid_next;
        m_tdata_reg     <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> rtl/mabt_store.sv
// Address store of the MAC address block table: one write port, one registered read port.
// Entries never written read as zero. Depends on mabt_pkg.
`default_nettype none

module mabt_store (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire mabt_pkg::store_req_t      req,
    output logic [mabt_pkg::ADDR_W-1:0]    rd_data
);
    import mabt_pkg::*;

    logic [ADDR_W-1:0]  mem [ENTRIES];
    logic [ENTRIES-1:0] written_reg;
    logic               rd_written_reg;
    logic [ADDR_W-1:0]  rd_mem_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_mem_reg <= mem[req.rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                written_reg[req.wr_addr] <= 1'b1;
            end
            rd_written_reg <= written_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_written_reg ? rd_mem_reg : '0;

endmodule

`default_nettype wire

>>> rtl/mabt_checker.sv
// Port checker for the MAC address block table, bound to the top level.
// Depends on mabt_pkg and watches only the top-level ports.
`default_nettype none

module mabt_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [mabt_pkg::M_TDATA_W-1:0] m_tdata
);
    import mabt_pkg::*;

    // The block works on one command at a time.
    a_busy_after_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while a command was in progress");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before its transfer");

    a_slot_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[6:2] == '0) && !m_tdata[7])
        else $error("slot or present flag set on a failed command");

    a_entry_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[71:8] == '0) && !m_tdata[72])
        else $error("entry fields set on a failed command");

endmodule

bind mac_address_block_table mabt_checker u_mabt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
